### src/dkh_pkg.sv
// shared types, codes and base decoding for the k-mer histogram
package dkh_pkg;

	typedef enum logic [1:0] {
		FUNC_FEED = 2'd0,
		FUNC_EOL  = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_T_UP = 8'h54;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_T_LO = 8'h74;

	localparam int unsigned CODE_W  = 10;
	localparam int unsigned COUNT_W = 32;

	typedef struct packed {
		logic              valid;
		logic [1:0]        code;
	} base_t;

	// what one transfer asks of the histogram stage
	typedef struct packed {
		logic              count;
		logic              read;
		logic              kmer_ready;
		logic [CODE_W-1:0] kmer_code;
	} kmer_req_t;

	typedef struct packed {
		logic               kmer_ready;
		logic [CODE_W-1:0]  kmer_code;
		logic [COUNT_W-1:0] bin_count;
	} kmer_res_t;

	function automatic base_t base_decode(input logic [7:0] ch);
		base_t b;
		b.valid = 1'b1;
		case (ch)
			CHAR_A_UP, CHAR_A_LO: b.code = 2'd0;
			CHAR_C_UP, CHAR_C_LO: b.code = 2'd1;
			CHAR_G_UP, CHAR_G_LO: b.code = 2'd2;
			CHAR_T_UP, CHAR_T_LO: b.code = 2'd3;
			default: begin
				b.valid = 1'b0;
				b.code  = 2'd0;
			end
		endcase
		return b;
	endfunction

endpackage

### src/dkh_if.sv
// item and result channel interfaces
interface dkh_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] symbol;
	logic [9:0] bin_index;

	modport source (output valid, output func, output symbol, output bin_index, input ready);
	modport sink (input valid, input func, input symbol, input bin_index, output ready);
endinterface

interface dkh_result_if;
	logic        valid;
	logic        ready;
	logic        kmer_ready;
	logic [9:0]  kmer_code;
	logic [31:0] bin_count;

	modport source (output valid, output kmer_ready, output kmer_code, output bin_count,
		input ready);
	modport sink (input valid, input kmer_ready, input kmer_code, input bin_count,
		output ready);
endinterface

### src/dkh_ram.sv
// generic single-clock ram, one write port, one registered read port
module dkh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/dkh_window.sv
// base decoding and the sliding window of recent bases
module dkh_window import dkh_pkg::*; #(
	parameter int unsigned KMER_LENGTH = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 func,
	input  logic [7:0]                 symbol,
	input  logic [9:0]                 bin_index,
	output kmer_req_t                  req,
	output logic [2*KMER_LENGTH-1:0]   addr
);

	localparam int unsigned AW = 2 * KMER_LENGTH;
	localparam int unsigned RW = 2 * (KMER_LENGTH - 1);
	localparam int unsigned HW = $clog2(KMER_LENGTH);

	logic [RW-1:0] recent_q;
	logic [HW-1:0] held_q;
	logic [RW-1:0] recent_d;
	logic [HW-1:0] held_d;
	base_t         base;
	logic [AW-1:0] code;
	logic          full;
	logic [AW+CODE_W-1:0] code_ext;
	logic [AW+CODE_W-1:0] idx_ext;

	assign base     = base_decode(symbol);
	assign code     = {recent_q, base.code};
	assign full     = (held_q == HW'(KMER_LENGTH - 1));
	assign code_ext = {{CODE_W{1'b0}}, code};
	assign idx_ext  = {{AW{1'b0}}, bin_index};

	always_comb begin
		req      = '0;
		addr     = code;
		recent_d = recent_q;
		held_d   = held_q;
		case (func)
			FUNC_FEED: begin
				if (base.valid) begin
					recent_d = code[RW-1:0];
					if (full) begin
						req.count      = 1'b1;
						req.kmer_ready = 1'b1;
						req.kmer_code  = code_ext[CODE_W-1:0];
					end else begin
						held_d = held_q + HW'(1);
					end
				end else begin
					recent_d = '0;
					held_d   = '0;
				end
			end
			FUNC_EOL: begin
				recent_d = '0;
				held_d   = '0;
			end
			FUNC_READ: begin
				req.read = 1'b1;
				addr     = idx_ext[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			held_q   <= '0;
		end else if (accept) begin
			recent_q <= recent_d;
			held_q   <= held_d;
		end
	end

endmodule

### src/dkh_histogram.sv
// count memory with clearing sweep, read-modify-write stage and write forwarding
module dkh_histogram import dkh_pkg::*; #(
	parameter int unsigned KMER_LENGTH = 5,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  kmer_req_t                req,
	input  logic [2*KMER_LENGTH-1:0] addr,
	input  logic                     advance,
	output logic                     valid_s1,
	output kmer_res_t                res,
	output logic                     busy
);

	localparam int unsigned AW    = 2 * KMER_LENGTH;
	localparam int unsigned DEPTH = 1 << AW;

	logic                   busy_q;
	logic [AW-1:0]          clr_addr_q;
	logic                   valid_s1_q;
	kmer_req_t              req_s1;
	logic [AW-1:0]          addr_s1;
	logic                   fwd_valid_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic                   move;
	logic                   upd;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH+COUNT_W-1:0] cnt_ext;

	assign move = valid_s1_q && advance;
	assign upd  = move && req_s1.count;

	// the ram is read-first, so the last write may be newer than rdata
	assign cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;
	assign nxt = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + COUNT_WIDTH'(1);

	assign ram_we    = busy_q || upd;
	assign ram_waddr = busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = busy_q ? '0 : nxt;

	dkh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (addr),
		.rdata (rdata)
	);

	assign cnt_ext = {{COUNT_W{1'b0}}, cur};

	always_comb begin
		res.kmer_ready = req_s1.kmer_ready;
		res.kmer_code  = req_s1.kmer_code;
		res.bin_count  = req_s1.read ? cnt_ext[COUNT_W-1:0] : '0;
	end

	assign valid_s1 = valid_s1_q;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (move) begin
				valid_s1_q <= 1'b0;
			end
			if (upd) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			addr_s1 <= addr;
		end
		if (upd) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

endmodule

### src/dna_kmer_histogram_top.sv
// k-mer histogram top: handshake, output register and checks
// result path: an accepted item is registered into the count stage (valid_s1), then into the output register
// throughput: one item per cycle unless clearing or stalled; counts are read, then written back
// repeated k-mers in consecutive items are served by forwarding the last write
// reset: window and handshake state clear at once; then a clearing pass zeroes all
// 4**KMER_LENGTH counts (1024 by default) while item.ready is low
module dna_kmer_histogram_top import dkh_pkg::*; #(
	parameter int unsigned KMER_LENGTH = 5,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	dkh_item_if.sink       item,
	dkh_result_if.source   result
);

	localparam int unsigned AW = 2 * KMER_LENGTH;

	logic          accept;
	logic          advance;
	logic          valid_s1;
	logic          busy;
	kmer_req_t     req;
	kmer_res_t     res;
	logic [AW-1:0] addr;
	logic          out_valid_q;
	kmer_res_t     out_q;

	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !busy && (!valid_s1 || advance);
	assign accept     = item.valid && item.ready;

	dkh_window #(
		.KMER_LENGTH(KMER_LENGTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (item.func),
		.symbol    (item.symbol),
		.bin_index (item.bin_index),
		.req       (req),
		.addr      (addr)
	);

	dkh_histogram #(
		.KMER_LENGTH(KMER_LENGTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_histogram (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.addr     (addr),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.res      (res),
		.busy     (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kmer_ready = out_q.kmer_ready;
	assign result.kmer_code  = out_q.kmer_code;
	assign result.bin_count  = out_q.bin_count;

	// nothing can be in flight while the counts are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!valid_s1 && !out_valid_q))
		else $error("item in flight during clearing pass");

	// a counted window comes from a feed transfer, which never reports a bin count
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kmer_ready) |-> (result.bin_count == '0))
		else $error("counted window carries a bin count");

	// every accepted transfer occupies the read-modify-write stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transfer lost before the count stage");

endmodule
